### rtl/teq_pkg.sv
// types and codes shared by the timer expiry queue
package teq_pkg;

    localparam int TIME_BITS = 48;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [15:0]          cancel_id;
        logic [TIME_BITS-1:0] deadline;
        logic [31:0]          interval_ms;
        logic [TIME_BITS-1:0] now_time;
    } in_word_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [1:0]           status;
        logic [15:0]          timer_id;
        logic [TIME_BITS-1:0] fired_deadline;
        logic                 rescheduled;
        logic                 last;
        logic                 nearest_valid;
        logic [TIME_BITS-1:0] nearest_deadline;
    } out_word_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_PICK = 6'b000100,
        ST_FIRE = 6'b001000,
        ST_NEAR = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

endpackage

### rtl/timer_expiry_queue_top.sv
// timer expiry queue: slot table scanned by one shared compare unit
//
// s_ channel takes one command word: add, cancel or tick. s_ready is high
// only while the block is idle; cmd 3 is taken and dropped.
// m_ channel returns the result words of that command, the final one
// marked by last. every word carries the nearest deadline after the step.
// add and cancel: a slot scan that stops at the first free slot or match,
// then a scan for the nearest deadline, then one result word.
// tick: a scan marks the due slots, then one pass per expired timer
// (a full scan for the smallest deadline and id, then a step to fire it),
// one more pass that finds none, the nearest scan, then one word per expiry,
// or one idle word if no timer fired. every scan walks the slots through
// the single compare and add path, one slot a cycle; the block returns to
// idle before it takes the next command.
// results are held in a word buffer while the receiver stalls; the block
// takes no new command until the last word is accepted.
// reset (aresetn low, synchronous) frees every slot and sets the next id
// to one; slot contents are not cleared.
module timer_expiry_queue_top
    import teq_pkg::*;
#(
    parameter int TIMER_SLOTS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    state_t state_reg;
    in_word_t in_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rd_reg;
    logic [TIMER_SLOTS-1:0] used_reg;
    logic [TIMER_SLOTS-1:0] due_reg;
    logic [15:0] next_id_reg;
    logic have_reg;
    logic [IW-1:0] best_reg;
    logic [TIME_BITS-1:0] best_dl_reg;
    logic [15:0] best_id_reg;
    logic [31:0] best_per_reg;
    logic near_valid_reg;
    logic [TIME_BITS-1:0] near_dl_reg;

    logic [TIME_BITS-1:0] dl_mem [TIMER_SLOTS];
    logic [31:0] per_mem [TIMER_SLOTS];
    logic [15:0] id_mem [TIMER_SLOTS];
    out_word_t res_mem [TIMER_SLOTS];

    logic [TIME_BITS-1:0] cur_dl;
    logic [15:0] cur_id;
    logic [31:0] cur_per;
    logic [TIME_BITS-1:0] now_t;
    logic [SW-1:0] sum;
    logic [TIME_BITS-1:0] resched_dl;
    logic add_hit;
    logic cancel_hit;
    logic push_en;
    out_word_t push_word;

    assign cur_dl  = dl_mem[idx_reg];
    assign cur_id  = id_mem[idx_reg];
    assign cur_per = per_mem[idx_reg];
    assign now_t   = TIME_BITS'(in_reg.now_time);
    assign sum     = SW'(now_t) + SW'(best_per_reg);
    assign resched_dl = (sum[SW-1:TIME_BITS] != '0) ? TIME_MAX : sum[TIME_BITS-1:0];

    assign add_hit    = (state_reg == ST_SCAN) && (in_reg.cmd == CMD_ADD) && !used_reg[idx_reg];
    assign cancel_hit = (state_reg == ST_SCAN) && (in_reg.cmd == CMD_CANCEL)
                        && used_reg[idx_reg] && (cur_id == in_reg.cancel_id);

    always_comb begin
        push_en   = 1'b0;
        push_word = '0;
        if (state_reg == ST_SCAN && in_reg.cmd == CMD_ADD) begin
            push_word.kind = KIND_ADD;
            if (add_hit) begin
                push_en = 1'b1;
                push_word.timer_id = next_id_reg;
            end else if (idx_reg == LAST_IDX) begin
                push_en = 1'b1;
                push_word.status = STAT_FULL;
            end
        end else if (state_reg == ST_SCAN && in_reg.cmd == CMD_CANCEL) begin
            push_word.kind     = KIND_CANCEL;
            push_word.timer_id = in_reg.cancel_id;
            if (cancel_hit) begin
                push_en = 1'b1;
            end else if (idx_reg == LAST_IDX) begin
                push_en = 1'b1;
                push_word.status = STAT_NOT_FOUND;
            end
        end else if (state_reg == ST_FIRE) begin
            if (have_reg) begin
                push_en = 1'b1;
                push_word.kind = KIND_FIRED;
                push_word.timer_id = best_id_reg;
                push_word.fired_deadline = best_dl_reg;
                push_word.rescheduled = (best_per_reg != '0);
            end else if (cnt_reg == '0) begin
                push_en = 1'b1;
                push_word.kind = KIND_IDLE;
            end
        end
    end

    // slot contents and result buffer
    always_ff @(posedge aclk) begin
        if (add_hit) begin
            dl_mem[idx_reg]  <= TIME_BITS'(in_reg.deadline);
            per_mem[idx_reg] <= in_reg.interval_ms;
            id_mem[idx_reg]  <= next_id_reg;
        end
        if (state_reg == ST_FIRE && have_reg && best_per_reg != '0) begin
            dl_mem[best_reg] <= resched_dl;
        end
        if (push_en) begin
            res_mem[cnt_reg[IW-1:0]] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            due_reg        <= '0;
            next_id_reg    <= 16'd1;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            rd_reg         <= '0;
            have_reg       <= 1'b0;
            near_valid_reg <= 1'b0;
        end else begin
            if (push_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg         <= s_data;
                        idx_reg        <= '0;
                        cnt_reg        <= '0;
                        rd_reg         <= '0;
                        have_reg       <= 1'b0;
                        near_valid_reg <= 1'b0;
                        if (s_data.cmd != CMD_NOP) begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (in_reg.cmd == CMD_TICK) begin
                        due_reg[idx_reg] <= used_reg[idx_reg] && (cur_dl <= now_t);
                    end else if (add_hit) begin
                        used_reg[idx_reg] <= 1'b1;
                        next_id_reg <= (next_id_reg == 16'hFFFF) ? 16'd1 : next_id_reg + 16'd1;
                    end else if (cancel_hit) begin
                        used_reg[idx_reg] <= 1'b0;
                    end
                    if (add_hit || cancel_hit || idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= (in_reg.cmd == CMD_TICK) ? ST_PICK : ST_NEAR;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_PICK: begin
                    if (due_reg[idx_reg] && (!have_reg || cur_dl < best_dl_reg
                        || (cur_dl == best_dl_reg && cur_id < best_id_reg))) begin
                        have_reg     <= 1'b1;
                        best_reg     <= idx_reg;
                        best_dl_reg  <= cur_dl;
                        best_id_reg  <= cur_id;
                        best_per_reg <= cur_per;
                    end
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= ST_FIRE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_FIRE: begin
                    if (have_reg) begin
                        have_reg          <= 1'b0;
                        due_reg[best_reg] <= 1'b0;
                        if (best_per_reg == '0) begin
                            used_reg[best_reg] <= 1'b0;
                        end
                        state_reg <= ST_PICK;
                    end else begin
                        state_reg <= ST_NEAR;
                    end
                end
                ST_NEAR: begin
                    if (used_reg[idx_reg] && (!near_valid_reg || cur_dl < near_dl_reg)) begin
                        near_valid_reg <= 1'b1;
                        near_dl_reg    <= cur_dl;
                    end
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        if (rd_reg == cnt_reg - 1'b1) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rd_reg <= rd_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);

    always_comb begin
        m_data = res_mem[rd_reg[IW-1:0]];
        m_data.last = (rd_reg == cnt_reg - 1'b1);
        m_data.nearest_valid = near_valid_reg;
        m_data.nearest_deadline = near_valid_reg ? near_dl_reg : '0;
    end

    a_emit_has_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (cnt_reg != '0))
        else $error("emitting with an empty word buffer");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(TIMER_SLOTS))
        else $error("word buffer overflow");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last) |=> s_ready)
        else $error("block not idle after last word");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while words pending");

endmodule
